// ===== src/shell_drill_rotation_projection_macros.svh =====
// Assertion macros for the drilling projection block
`ifndef SHELL_DRILL_ROTATION_PROJECTION_MACROS_SVH
`define SHELL_DRILL_ROTATION_PROJECTION_MACROS_SVH

`ifndef ASSERT_OFF
`define SDRP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdrp assertion failed");
`define SDRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdrp assertion failed");
`else
`define SDRP_ASSERT_IMPL(lbl, ante, cons)
`define SDRP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/sdrp_pkg.sv =====
package sdrp_pkg;

    localparam int IN_W       = 288;
    localparam int OUT_W      = 200;
    localparam int MUL_W      = 34;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    localparam logic [1:0] NBR_TAB [12] = '{
        2'd0, 2'd1, 2'd3,
        2'd1, 2'd2, 2'd0,
        2'd2, 2'd3, 2'd1,
        2'd3, 2'd0, 2'd2
    };

    function automatic logic [3:0] node_idx(input logic [1:0] node, input logic [1:0] comp);
        return {2'b00, node} * 4'd3 + {2'b00, comp};
    endfunction

    function automatic logic [1:0] nbr(input logic [1:0] node, input logic [1:0] which);
        return NBR_TAB[node_idx(node, which)];
    endfunction

endpackage

// ===== src/shell_drill_rotation_projection.sv =====
// Drilling-rotation projection for a four-node shell element. Nodes arrive one per item
// (position, force, moment, signed Q16.16); the first three are only stored.
// The fourth starts the per-node pass: for each node in turn the edge cross product, its
// normalization, the square root, three divisions and the projection run through one shared
// registered 34x34 multiplier, a bit-serial square root (32 steps) and a bit-serial divider
// (31 steps per component). The cross product is normalized one shift at a time; when it
// is zero, the normalization, root and divisions are skipped and the unit vector is zero.
// Results leave in node order, tlast on node 3; the block takes no item until the last
// result is taken.
module shell_drill_rotation_projection (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_x, pos_y, pos_z, force_x, force_y, force_z, moment_x, moment_y, moment_z
    input  logic [sdrp_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // node_number, out_force_x/y/z, proj_moment_x/y/z, zero fill
    output logic [sdrp_pkg::OUT_W-1:0]  m_axis_tdata,
    // last_node
    output logic                        m_axis_tlast
);
    import sdrp_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EDGE   = 4'd1;
    localparam logic [3:0] ST_ESHIFT = 4'd2;
    localparam logic [3:0] ST_CROSS  = 4'd3;
    localparam logic [3:0] ST_CMAX   = 4'd4;
    localparam logic [3:0] ST_NORM   = 4'd5;
    localparam logic [3:0] ST_SQ     = 4'd6;
    localparam logic [3:0] ST_ROOT   = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_DOT    = 4'd9;
    localparam logic [3:0] ST_DFIN   = 4'd10;
    localparam logic [3:0] ST_CORR   = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    logic [3:0]         state_reg;
    logic [1:0]         load_count_reg;
    logic [1:0]         node_reg;
    logic [1:0]         t_reg;
    logic [2:0]         step_reg;
    logic               ph_reg;
    logic               out_valid_reg;

    logic signed [31:0] pos_reg   [12];
    logic        [31:0] force_reg [12];
    logic signed [31:0] mom_reg   [12];
    logic signed [32:0] a_reg     [3];
    logic signed [32:0] b_reg     [3];
    logic        [32:0] emx_reg;
    logic signed [63:0] c_reg     [3];
    logic        [63:0] cmx_reg;
    logic        [63:0] sum_reg;
    logic        [31:0] nrm_reg;
    logic signed [31:0] e3_reg    [3];
    logic signed [65:0] acc_reg;
    logic signed [33:0] d_reg;
    logic signed [31:0] proj_reg  [3];

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod;

    logic               root_start;
    logic               root_done;
    logic [31:0]        root_val;
    logic               div_start;
    logic               div_done;
    logic [30:0]        quo;
    logic [63:0]        c_abs;

    logic signed [31:0] pi;
    logic signed [31:0] pj;
    logic signed [31:0] pk;
    logic signed [32:0] ea;
    logic signed [32:0] eb;
    logic        [32:0] ma;
    logic        [32:0] mb;
    logic        [32:0] emx_new;
    logic        [1:0]  esh;
    logic        [63:0] cm0;
    logic        [63:0] cm1;
    logic        [63:0] cm2;
    logic        [63:0] cm01;
    logic        [63:0] cmax;
    logic signed [65:0] dsum;
    logic signed [67:0] qsum;
    logic signed [38:0] qdiff;
    logic signed [31:0] m_cur;

    function automatic logic signed [31:0] sat32(input logic signed [38:0] x);
        if (x > 39'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (x < -39'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    assign pi = pos_reg[node_idx(nbr(node_reg, 2'd0), t_reg)];
    assign pj = pos_reg[node_idx(nbr(node_reg, 2'd1), t_reg)];
    assign pk = pos_reg[node_idx(nbr(node_reg, 2'd2), t_reg)];
    assign ea = 33'(pj) - 33'(pi);
    assign eb = 33'(pk) - 33'(pi);
    assign ma = ea[32] ? 33'(-ea) : 33'(ea);
    assign mb = eb[32] ? 33'(-eb) : 33'(eb);

    always_comb
    begin
        emx_new = emx_reg;
        if (ma > emx_new)
        begin
            emx_new = ma;
        end
        if (mb > emx_new)
        begin
            emx_new = mb;
        end
    end

    assign esh = emx_reg[32] ? 2'd3 : emx_reg[31] ? 2'd2 : emx_reg[30] ? 2'd1 : 2'd0;

    assign cm0  = c_reg[0][63] ? 64'(-c_reg[0]) : 64'(c_reg[0]);
    assign cm1  = c_reg[1][63] ? 64'(-c_reg[1]) : 64'(c_reg[1]);
    assign cm2  = c_reg[2][63] ? 64'(-c_reg[2]) : 64'(c_reg[2]);
    assign cm01 = (cm1 > cm0) ? cm1 : cm0;
    assign cmax = (cm2 > cm01) ? cm2 : cm01;

    assign c_abs = c_reg[t_reg][63] ? 64'(-c_reg[t_reg]) : 64'(c_reg[t_reg]);

    assign m_cur = mom_reg[node_idx(node_reg, step_reg[1:0])];
    assign dsum  = acc_reg + 66'sd536870912;
    assign qsum  = prod + 68'sd536870912;
    assign qdiff = 39'(m_cur) - 39'($signed(qsum[67:30]));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CROSS:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(a_reg[1]);
                        mul_b = MUL_W'(b_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(a_reg[2]);
                        mul_b = MUL_W'(b_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(a_reg[2]);
                        mul_b = MUL_W'(b_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(a_reg[0]);
                        mul_b = MUL_W'(b_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = MUL_W'(a_reg[0]);
                        mul_b = MUL_W'(b_reg[1]);
                    end
                    default:
                    begin
                        mul_a = MUL_W'(a_reg[1]);
                        mul_b = MUL_W'(b_reg[0]);
                    end
                endcase
            end
            ST_SQ:
            begin
                mul_a = c_reg[step_reg[1:0]][MUL_W-1:0];
                mul_b = c_reg[step_reg[1:0]][MUL_W-1:0];
            end
            ST_DOT:
            begin
                mul_a = MUL_W'(m_cur);
                mul_b = MUL_W'(e3_reg[step_reg[1:0]]);
            end
            ST_CORR:
            begin
                mul_a = MUL_W'(d_reg);
                mul_b = MUL_W'(e3_reg[step_reg[1:0]]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sdrp_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign root_start = (state_reg == ST_ROOT) && !ph_reg;
    assign div_start  = (state_reg == ST_DIV) && !ph_reg;

    sdrp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (root_val)
    );

    sdrp_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_mag (c_abs[30:0]),
        .divisor      (nrm_reg),
        .done         (div_done),
        .quotient     (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            node_reg       <= '0;
            t_reg          <= '0;
            step_reg       <= '0;
            ph_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        for (int f = 0; f < 3; f++)
                        begin
                            pos_reg[node_idx(load_count_reg, 2'(f))]   <= s_axis_tdata[32*f +: 32];
                            force_reg[node_idx(load_count_reg, 2'(f))] <=
                                s_axis_tdata[32*(f+3) +: 32];
                            mom_reg[node_idx(load_count_reg, 2'(f))]   <=
                                s_axis_tdata[32*(f+6) +: 32];
                        end
                        load_count_reg <= load_count_reg + 2'd1;
                        if (load_count_reg == 2'd3)
                        begin
                            node_reg  <= '0;
                            t_reg     <= '0;
                            emx_reg   <= '0;
                            state_reg <= ST_EDGE;
                        end
                    end
                end
                ST_EDGE:
                begin
                    a_reg[t_reg] <= ea;
                    b_reg[t_reg] <= eb;
                    emx_reg      <= emx_new;
                    t_reg        <= t_reg + 2'd1;
                    if (t_reg == 2'd2)
                    begin
                        t_reg     <= '0;
                        state_reg <= ST_ESHIFT;
                    end
                end
                ST_ESHIFT:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        a_reg[k] <= a_reg[k] >>> esh;
                        b_reg[k] <= b_reg[k] >>> esh;
                        c_reg[k] <= '0;
                    end
                    step_reg  <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= ST_CROSS;
                end
                ST_CROSS:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (step_reg[0])
                        begin
                            c_reg[step_reg[2:1]] <= c_reg[step_reg[2:1]] - prod[63:0];
                        end
                        else
                        begin
                            c_reg[step_reg[2:1]] <= c_reg[step_reg[2:1]] + prod[63:0];
                        end
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd5)
                        begin
                            state_reg <= ST_CMAX;
                        end
                    end
                end
                ST_CMAX:
                begin
                    cmx_reg  <= cmax;
                    step_reg <= '0;
                    ph_reg   <= 1'b0;
                    if (cmax == '0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            e3_reg[k] <= '0;
                        end
                        acc_reg   <= '0;
                        state_reg <= ST_DOT;
                    end
                    else
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (cmx_reg >= 64'd1073741824)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            c_reg[k] <= c_reg[k] >>> 1;
                        end
                        cmx_reg <= cmx_reg >> 1;
                    end
                    else if (cmx_reg < 64'd536870912)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            c_reg[k] <= c_reg[k] <<< 1;
                        end
                        cmx_reg <= cmx_reg << 1;
                    end
                    else
                    begin
                        sum_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        sum_reg  <= sum_reg + prod[63:0];
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd2)
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_ROOT;
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (!ph_reg)
                    begin
                        ph_reg <= 1'b1;
                    end
                    else if (root_done)
                    begin
                        nrm_reg   <= root_val;
                        t_reg     <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (!ph_reg)
                    begin
                        ph_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        e3_reg[t_reg] <= c_reg[t_reg][63] ? -32'(quo) : 32'(quo);
                        ph_reg        <= 1'b0;
                        t_reg         <= t_reg + 2'd1;
                        if (t_reg == 2'd2)
                        begin
                            t_reg     <= '0;
                            acc_reg   <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_DOT;
                        end
                    end
                end
                ST_DOT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        acc_reg  <= acc_reg + prod[65:0];
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd2)
                        begin
                            state_reg <= ST_DFIN;
                        end
                    end
                end
                ST_DFIN:
                begin
                    d_reg     <= dsum[63:30];
                    step_reg  <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= ST_CORR;
                end
                ST_CORR:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        proj_reg[step_reg[1:0]] <= sat32(qdiff);
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd2)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (node_reg == 2'd3)
                        begin
                            node_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            node_reg  <= node_reg + 2'd1;
                            t_reg     <= '0;
                            emx_reg   <= '0;
                            state_reg <= ST_EDGE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = (node_reg == 2'd3);
    assign m_axis_tdata  = {6'b0, proj_reg[2], proj_reg[1], proj_reg[0],
                            force_reg[node_idx(node_reg, 2'd2)],
                            force_reg[node_idx(node_reg, 2'd1)],
                            force_reg[node_idx(node_reg, 2'd0)],
                            node_reg};

`include "shell_drill_rotation_projection_macros.svh"

    `SDRP_ASSERT_IMPL(a_ready_no_result, s_axis_tready, !m_axis_tvalid)
    `SDRP_ASSERT_NEXT(a_last_to_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                      s_axis_tready)
    `SDRP_ASSERT_NEXT(a_fourth_starts, s_axis_tvalid && s_axis_tready && load_count_reg == 2'd3,
                      !s_axis_tready && load_count_reg == 2'd0)

endmodule

// ===== src/sdrp_mul.sv =====
module sdrp_mul (
    input  logic                                clk,
    input  logic signed [sdrp_pkg::MUL_W-1:0]   op_a,
    input  logic signed [sdrp_pkg::MUL_W-1:0]   op_b,
    output logic signed [2*sdrp_pkg::MUL_W-1:0] prod
);
    import sdrp_pkg::*;

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== src/sdrp_isqrt.sv =====
module sdrp_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import sdrp_pkg::*;

    localparam int CntW = $clog2(SQRT_STEPS);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [63:0]     v_reg;
    logic [63:0]     res_reg;
    logic [63:0]     bit_val;
    logic [63:0]     trial;
    logic            take;

    assign bit_val = 64'd1 << (7'd62 - {1'b0, cnt_reg, 1'b0});
    assign trial   = res_reg + bit_val;
    assign take    = (v_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                v_reg    <= radicand;
                res_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (take)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_val;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== src/sdrp_div.sv =====
module sdrp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] dividend_mag,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [30:0] quotient
);
    import sdrp_pkg::*;

    localparam int CntW = $clog2(DIV_STEPS);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [30:0]     mag_reg;
    logic [31:0]     div_reg;
    logic [31:0]     rem_reg;
    logic [30:0]     quo_reg;
    logic [32:0]     rin;
    logic [32:0]     diff;
    logic            ge;

    assign rin  = (cnt_reg == '0) ? {2'b00, mag_reg} : {rem_reg, 1'b0};
    assign diff = rin - {1'b0, div_reg};
    assign ge   = (rin >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mag_reg  <= dividend_mag;
                div_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[31:0] : rin[31:0];
                quo_reg <= {quo_reg[29:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
